// ===== sv/plar_pkg.sv =====
// Shared types, constants and helper functions for the polyline resampler.
`timescale 1ns / 1ps
package plar_pkg;

   localparam int MAX_IMAGES = 8;
   localparam int MAX_DIMS   = 8;
   localparam int STORE_CAP  = MAX_IMAGES * MAX_DIMS;
   localparam int ADDR_W     = $clog2(STORE_CAP);
   localparam int IMG_W      = $clog2(MAX_IMAGES);
   localparam int DIM_W      = $clog2(MAX_DIMS);
   localparam int CNT_W      = 4;
   localparam int LOAD_W     = ADDR_W + 1;

   typedef enum logic [1:0] {
      REG_INV_MASS    = 2'd0,
      REG_STEP_TIME   = 2'd1,
      REG_IMAGE_COUNT = 2'd2,
      REG_DIM_COUNT   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ALU_MUL  = 2'd0,
      ALU_DIV  = 2'd1,
      ALU_SQRT = 2'd2
   } alu_op_type;

   typedef enum logic [1:0] {
      ALU_IDLE = 2'd0,
      ALU_RUN  = 2'd1,
      ALU_DONE = 2'd2
   } alu_state_type;

   typedef enum logic [4:0] {
      S_IDLE, S_QDIV, S_GAIN1, S_GAIN2,
      S_LEN_RA, S_LEN_RB, S_LEN_SQ, S_LEN_RT,
      S_FRAC, S_TGT, S_WALK, S_FDIV,
      S_INT_RA, S_INT_RB, S_INT_MUL,
      S_COPY_RD, S_COPY_WR
   } ctrl_state_type;

   typedef struct packed {
      logic [31:0]      inv_mass;
      logic [31:0]      step_time;
      logic [CNT_W-1:0] image_count;
      logic [CNT_W-1:0] dim_count;
   } cfg_type;

   typedef struct packed {
      logic       go;
      alu_op_type op;
   } alu_req_type;

   function automatic logic [CNT_W-1:0] clamp_images(input logic [CNT_W-1:0] v);
      if (v < CNT_W'(2)) return CNT_W'(2);
      else if (v > CNT_W'(MAX_IMAGES)) return CNT_W'(MAX_IMAGES);
      else return v;
   endfunction

   function automatic logic [CNT_W-1:0] clamp_dims(input logic [CNT_W-1:0] v);
      if (v < CNT_W'(1)) return CNT_W'(1);
      else if (v > CNT_W'(MAX_DIMS)) return CNT_W'(MAX_DIMS);
      else return v;
   endfunction

   // target spacing: floor((2^31 - 1) / (images - 1))
   function automatic logic [31:0] step_of(input logic [CNT_W-1:0] n);
      case (n)
         CNT_W'(2): return 32'h7FFFFFFF / 32'd1;
         CNT_W'(3): return 32'h7FFFFFFF / 32'd2;
         CNT_W'(4): return 32'h7FFFFFFF / 32'd3;
         CNT_W'(5): return 32'h7FFFFFFF / 32'd4;
         CNT_W'(6): return 32'h7FFFFFFF / 32'd5;
         CNT_W'(7): return 32'h7FFFFFFF / 32'd6;
         CNT_W'(8): return 32'h7FFFFFFF / 32'd7;
         default:   return 32'h7FFFFFFF;
      endcase
   endfunction

   function automatic logic [31:0] sat32(input logic signed [63:0] x);
      if (x > 64'sd2147483647) return 32'h7FFFFFFF;
      else if (x < -64'sd2147483648) return 32'h80000000;
      else return x[31:0];
   endfunction

endpackage

// ===== sv/plar_alu.sv =====
// Shared iterative arithmetic unit: signed multiply, restoring divide, integer square root.
`timescale 1ns / 1ps
module plar_alu import plar_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  alu_req_type req,
   input  logic [63:0] opa,
   input  logic [63:0] opb,
   output logic        done,
   output logic [63:0] result
);

   alu_state_type state_ff, state_in;
   alu_op_type    op_ff, op_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic [63:0]   x_ff, x_in;
   logic [63:0]   y_ff, y_in;
   logic [34:0]   rem_ff, rem_in;
   logic [63:0]   root_ff, root_in;
   logic [63:0]   bit_ff, bit_in;
   logic [63:0]   res_ff, res_in;

   logic signed [65:0] prod;
   logic [34:0]        rem_sh;
   logic [63:0]        trial;
   logic               last_iter;

   assign prod   = $signed(x_ff[32:0]) * $signed(y_ff[32:0]);
   assign rem_sh = {rem_ff[33:0], x_ff[63]};
   assign trial  = root_ff + bit_ff;

   always_comb begin
      case (op_ff)
         ALU_MUL:  last_iter = 1'b1;
         ALU_DIV:  last_iter = (cnt_ff == 6'd63);
         ALU_SQRT: last_iter = (cnt_ff == 6'd31);
         default:  last_iter = 1'b1;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ALU_IDLE: if (req.go) state_in = ALU_RUN;
         ALU_RUN:  if (last_iter) state_in = ALU_DONE;
         ALU_DONE: state_in = ALU_IDLE;
         default:  state_in = ALU_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      done   = (state_ff == ALU_DONE);
      result = res_ff;
   end

   // datapath
   always_comb begin
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      res_in  = res_ff;
      case (state_ff)
         ALU_IDLE: begin
            if (req.go) begin
               op_in   = req.op;
               x_in    = opa;
               y_in    = opb;
               rem_in  = '0;
               root_in = '0;
               bit_in  = 64'h4000000000000000;
               cnt_in  = '0;
            end
         end
         ALU_RUN: begin
            cnt_in = cnt_ff + 6'd1;
            case (op_ff)
               ALU_MUL: res_in = prod[63:0];
               ALU_DIV: begin
                  // one quotient bit per cycle
                  if (rem_sh >= {1'b0, y_ff[33:0]}) begin
                     rem_in = rem_sh - {1'b0, y_ff[33:0]};
                     x_in   = {x_ff[62:0], 1'b1};
                  end else begin
                     rem_in = rem_sh;
                     x_in   = {x_ff[62:0], 1'b0};
                  end
                  res_in = x_in;
               end
               ALU_SQRT: begin
                  // one root bit per cycle
                  if (x_ff >= trial) begin
                     x_in    = x_ff - trial;
                     root_in = (root_ff >> 1) + bit_ff;
                  end else begin
                     root_in = root_ff >> 1;
                  end
                  bit_in = bit_ff >> 2;
                  res_in = root_in;
               end
               default: res_in = res_ff;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ALU_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff   <= op_in;
      cnt_ff  <= cnt_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      res_ff  <= res_in;
   end

endmodule

// ===== sv/plar_ctrl.sv =====
// Sequencer, coordinate stores and datapath registers of the resampler.
`timescale 1ns / 1ps
module plar_ctrl import plar_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        cfg_wr,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_pos_value,
   input  logic [31:0] req_grad_value,
   input  logic        req_last_element,
   output logic        rsp_valid,
   output logic [31:0] rsp_new_value,
   output logic        rsp_error_flag,
   output logic        rsp_last_result,
   output alu_req_type alu_req,
   output logic [63:0] alu_opa,
   output logic [63:0] alu_opb,
   input  logic        alu_done,
   input  logic [63:0] alu_result
);

   ctrl_state_type state_ff, state_in;

   logic [31:0]        pos_ff, pos_in;
   logic [31:0]        grad_ff, grad_in;
   logic               last_ff, last_in;
   logic [31:0]        quo_ff, quo_in;
   logic               quo_ok_ff, quo_ok_in;
   logic signed [63:0] acc_ff, acc_in;
   logic [LOAD_W-1:0]  load_idx_ff, load_idx_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [CNT_W-1:0]   m_ff, m_in;
   logic [LOAD_W-1:0]  nm_ff, nm_in;
   logic [IMG_W-1:0]   i_ff, i_in;
   logic [DIM_W-1:0]   d_ff, d_in;
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [63:0]        sq_ff, sq_in;
   logic [33:0]        total_ff, total_in;
   logic [31:0]        raw_ff [MAX_IMAGES];
   logic [31:0]        raw_in [MAX_IMAGES];
   logic [31:0]        sum_ff, sum_in;
   logic [31:0]        seg_ff [MAX_IMAGES];
   logic [31:0]        seg_in [MAX_IMAGES];
   logic [31:0]        target_ff, target_in;
   logic [31:0]        prev_ff, prev_in;
   logic [31:0]        s_ff, s_in;
   logic [IMG_W-1:0]   left_ff, left_in;
   logic [ADDR_W-1:0]  lbase_ff, lbase_in;
   logic [31:0]        f_ff, f_in;
   logic               err_ff, err_in;
   logic [31:0]        a_ff, a_in;
   logic [ADDR_W-1:0]  out_idx_ff, out_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_value_ff, rsp_value_in;
   logic               rsp_err_ff, rsp_err_in;
   logic               rsp_last_ff, rsp_last_in;

   // coordinate store and fresh-result buffer
   logic [31:0]       coord_mem [STORE_CAP];
   logic [31:0]       fresh_mem [STORE_CAP];
   logic [31:0]       coord_rd_ff, fresh_rd_ff;
   logic              coord_we, coord_re, fresh_we, fresh_re;
   logic [ADDR_W-1:0] coord_wa, coord_ra, fresh_wa, fresh_ra;
   logic [31:0]       coord_wd, fresh_wd;

   // shared datapath helpers
   logic signed [63:0] res_s, g_term, i_term, c_val, v_val;
   logic signed [32:0] diff;
   logic [32:0]        absd;
   logic [28:0]        qv;
   logic [31:0]        seg_cur, fr_val, step;
   logic               last_seg, last_left, frac_div, need_div, last_dim, last_img;
   logic [ADDR_W-1:0]  m_a;

   assign res_s     = $signed(alu_result);
   assign g_term    = (res_s + 64'sd8388608) >>> 24;
   assign i_term    = (res_s + 64'sd1073741824) >>> 31;
   assign c_val     = acc_ff + g_term;
   assign v_val     = {{32{a_ff[31]}}, a_ff} + i_term;
   assign diff      = {coord_rd_ff[31], coord_rd_ff} - {a_ff[31], a_ff};
   assign absd      = diff[32] ? 33'(-diff) : 33'(diff);
   assign qv        = 29'((absd + 33'd8) >> 4);
   assign seg_cur   = seg_ff[left_ff];
   assign step      = step_of(n_ff);
   assign m_a       = ADDR_W'(m_ff);
   assign last_seg  = ({1'b0, i_ff} + CNT_W'(2) == n_ff);
   assign last_left = ({1'b0, left_ff} + CNT_W'(2) == n_ff);
   assign last_dim  = ({1'b0, d_ff} == m_ff - CNT_W'(1));
   assign last_img  = ({1'b0, i_ff} == n_ff - CNT_W'(1));
   assign frac_div  = (total_ff != '0) && !last_seg;
   assign need_div  = !err_ff && (seg_cur != '0);
   assign fr_val    = (total_ff == '0) ? 32'd0 :
                      last_seg ? (32'h80000000 - sum_ff) : alu_result[31:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:
            if (start)
               state_in = (!quo_ok_ff && cfg.inv_mass != '0) ? S_QDIV : S_GAIN1;
         S_QDIV:   if (alu_done) state_in = S_GAIN1;
         S_GAIN1:  if (alu_done) state_in = S_GAIN2;
         S_GAIN2:  if (alu_done) state_in = last_ff ? S_LEN_RA : S_IDLE;
         S_LEN_RA: state_in = S_LEN_RB;
         S_LEN_RB: state_in = S_LEN_SQ;
         S_LEN_SQ: if (alu_done) state_in = last_dim ? S_LEN_RT : S_LEN_RA;
         S_LEN_RT: if (alu_done) state_in = last_seg ? S_FRAC : S_LEN_RA;
         S_FRAC:   if (!frac_div || alu_done) state_in = last_seg ? S_TGT : S_FRAC;
         S_TGT:    state_in = S_WALK;
         S_WALK:
            if (err_ff || s_ff <= seg_cur || last_left) state_in = S_FDIV;
         S_FDIV:   if (!need_div || alu_done) state_in = S_INT_RA;
         S_INT_RA: state_in = S_INT_RB;
         S_INT_RB: state_in = S_INT_MUL;
         S_INT_MUL:
            if (alu_done) begin
               if (!last_dim) state_in = S_INT_RA;
               else if (last_img) state_in = S_COPY_RD;
               else state_in = S_TGT;
            end
         S_COPY_RD: state_in = S_COPY_WR;
         S_COPY_WR:
            if ({1'b0, out_idx_ff} == nm_ff - LOAD_W'(1)) state_in = S_IDLE;
            else state_in = S_COPY_RD;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy            = (state_ff != S_IDLE);
      rsp_valid       = rsp_valid_ff;
      rsp_new_value   = rsp_value_ff;
      rsp_error_flag  = rsp_err_ff;
      rsp_last_result = rsp_last_ff;
   end

   // datapath and unit requests
   always_comb begin
      pos_in       = pos_ff;
      grad_in      = grad_ff;
      last_in      = last_ff;
      quo_in       = quo_ff;
      quo_ok_in    = quo_ok_ff;
      acc_in       = acc_ff;
      load_idx_in  = load_idx_ff;
      n_in         = n_ff;
      m_in         = m_ff;
      nm_in        = nm_ff;
      i_in         = i_ff;
      d_in         = d_ff;
      base_in      = base_ff;
      sq_in        = sq_ff;
      total_in     = total_ff;
      raw_in       = raw_ff;
      sum_in       = sum_ff;
      seg_in       = seg_ff;
      target_in    = target_ff;
      prev_in      = prev_ff;
      s_in         = s_ff;
      left_in      = left_ff;
      lbase_in     = lbase_ff;
      f_in         = f_ff;
      err_in       = err_ff;
      a_in         = a_ff;
      out_idx_in   = out_idx_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_last_in  = rsp_last_ff;
      alu_req.go   = 1'b0;
      alu_req.op   = ALU_MUL;
      alu_opa      = '0;
      alu_opb      = '0;
      coord_we     = 1'b0;
      coord_wa     = '0;
      coord_wd     = '0;
      coord_re     = 1'b0;
      coord_ra     = '0;
      fresh_we     = 1'b0;
      fresh_wa     = '0;
      fresh_wd     = '0;
      fresh_re     = 1'b0;
      fresh_ra     = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               pos_in  = req_pos_value;
               grad_in = req_grad_value;
               last_in = req_last_element;
               n_in    = clamp_images(cfg.image_count);
               m_in    = clamp_dims(cfg.dim_count);
               nm_in   = LOAD_W'(n_in) * LOAD_W'(m_in);
               left_in = '0;
               if (!quo_ok_ff && cfg.inv_mass == '0) begin
                  quo_in    = 32'hFFFFFFFF;
                  quo_ok_in = 1'b1;
               end
            end
         end
         S_QDIV: begin
            // step_time / inverse_mass in Q8.24, saturating
            alu_req.go = 1'b1;
            alu_req.op = ALU_DIV;
            alu_opa    = {8'd0, cfg.step_time, 24'd0};
            alu_opb    = {32'd0, cfg.inv_mass};
            if (alu_done) begin
               quo_in    = (alu_result[63:32] != '0) ? 32'hFFFFFFFF : alu_result[31:0];
               quo_ok_in = 1'b1;
            end
         end
         S_GAIN1: begin
            alu_req.go = 1'b1;
            alu_opa    = {{32{grad_ff[31]}}, grad_ff};
            alu_opb    = {32'd0, cfg.inv_mass};
            if (alu_done) acc_in = $signed({{32{pos_ff[31]}}, pos_ff}) - g_term;
         end
         S_GAIN2: begin
            alu_req.go = 1'b1;
            alu_opa    = {{32{grad_ff[31]}}, grad_ff};
            alu_opb    = {32'd0, quo_ff};
            if (alu_done) begin
               if (load_idx_ff < LOAD_W'(STORE_CAP)) begin
                  coord_we    = 1'b1;
                  coord_wa    = load_idx_ff[ADDR_W-1:0];
                  coord_wd    = sat32(c_val);
                  load_idx_in = load_idx_ff + LOAD_W'(1);
               end
               if (last_ff) begin
                  load_idx_in = '0;
                  i_in        = '0;
                  d_in        = '0;
                  base_in     = '0;
                  sq_in       = '0;
                  total_in    = '0;
               end
            end
         end
         S_LEN_RA: begin
            coord_re = 1'b1;
            coord_ra = base_ff + ADDR_W'(d_ff);
         end
         S_LEN_RB: begin
            coord_re = 1'b1;
            coord_ra = base_ff + m_a + ADDR_W'(d_ff);
            a_in     = coord_rd_ff;
         end
         S_LEN_SQ: begin
            alu_req.go = 1'b1;
            alu_opa    = {35'd0, qv};
            alu_opb    = {35'd0, qv};
            if (alu_done) begin
               sq_in = sq_ff + alu_result;
               d_in  = last_dim ? '0 : d_ff + DIM_W'(1);
            end
         end
         S_LEN_RT: begin
            alu_req.go = 1'b1;
            alu_req.op = ALU_SQRT;
            alu_opa    = sq_ff;
            if (alu_done) begin
               raw_in[i_ff] = alu_result[31:0];
               total_in     = total_ff + 34'(alu_result[31:0]);
               i_in         = i_ff + IMG_W'(1);
               base_in      = base_ff + m_a;
               sq_in        = '0;
               if (last_seg) begin
                  i_in   = '0;
                  sum_in = '0;
               end
            end
         end
         S_FRAC: begin
            alu_req.go = frac_div;
            alu_req.op = ALU_DIV;
            alu_opa    = {1'b0, raw_ff[i_ff], 31'd0};
            alu_opb    = {30'd0, total_ff};
            if (!frac_div || alu_done) begin
               seg_in[i_ff] = fr_val;
               sum_in       = sum_ff + fr_val;
               i_in         = i_ff + IMG_W'(1);
               if (last_seg) begin
                  i_in       = '0;
                  d_in       = '0;
                  target_in  = '0;
                  prev_in    = '0;
                  left_in    = '0;
                  lbase_in   = '0;
                  err_in     = 1'b0;
                  out_idx_in = '0;
               end
            end
         end
         S_TGT: s_in = (target_ff > prev_ff) ? target_ff - prev_ff : 32'd0;
         S_WALK: begin
            // one segment per cycle
            if (!err_ff && s_ff > seg_cur) begin
               if (last_left) begin
                  err_in = 1'b1;
               end else begin
                  prev_in  = prev_ff + seg_cur;
                  s_in     = s_ff - seg_cur;
                  left_in  = left_ff + IMG_W'(1);
                  lbase_in = lbase_ff + m_a;
               end
            end
         end
         S_FDIV: begin
            alu_req.go = need_div;
            alu_req.op = ALU_DIV;
            alu_opa    = {1'b0, s_ff, 31'd0};
            alu_opb    = {32'd0, seg_cur};
            if (err_ff) f_in = 32'h80000000;
            else if (seg_cur == '0) f_in = 32'd0;
            else if (alu_done) f_in = alu_result[31:0];
         end
         S_INT_RA: begin
            coord_re = 1'b1;
            coord_ra = lbase_ff + ADDR_W'(d_ff);
         end
         S_INT_RB: begin
            coord_re = 1'b1;
            coord_ra = lbase_ff + m_a + ADDR_W'(d_ff);
            a_in     = coord_rd_ff;
         end
         S_INT_MUL: begin
            alu_req.go = 1'b1;
            alu_opa    = {{31{diff[32]}}, diff};
            alu_opb    = {32'd0, f_ff};
            if (alu_done) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = sat32(v_val);
               rsp_err_in   = err_ff;
               rsp_last_in  = last_dim && last_img;
               fresh_we     = 1'b1;
               fresh_wa     = out_idx_ff;
               fresh_wd     = sat32(v_val);
               out_idx_in   = out_idx_ff + ADDR_W'(1);
               d_in         = last_dim ? '0 : d_ff + DIM_W'(1);
               if (last_dim) begin
                  i_in      = i_ff + IMG_W'(1);
                  target_in = target_ff + step;
                  if (last_img) out_idx_in = '0;
               end
            end
         end
         S_COPY_RD: begin
            fresh_re = 1'b1;
            fresh_ra = out_idx_ff;
         end
         S_COPY_WR: begin
            coord_we   = 1'b1;
            coord_wa   = out_idx_ff;
            coord_wd   = fresh_rd_ff;
            out_idx_in = out_idx_ff + ADDR_W'(1);
         end
         default: ;
      endcase
      // new gains invalidate the cached quotient
      if (cfg_wr) quo_ok_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (coord_we) coord_mem[coord_wa] <= coord_wd;
      if (coord_re) coord_rd_ff <= coord_mem[coord_ra];
   end

   always_ff @(posedge clock) begin
      if (fresh_we) fresh_mem[fresh_wa] <= fresh_wd;
      if (fresh_re) fresh_rd_ff <= fresh_mem[fresh_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         quo_ok_ff    <= 1'b0;
         load_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         n_ff         <= CNT_W'(2);
         left_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         quo_ok_ff    <= quo_ok_in;
         load_idx_ff  <= load_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         n_ff         <= n_in;
         left_ff      <= left_in;
      end
      pos_ff       <= pos_in;
      grad_ff      <= grad_in;
      last_ff      <= last_in;
      quo_ff       <= quo_in;
      acc_ff       <= acc_in;
      m_ff         <= m_in;
      nm_ff        <= nm_in;
      i_ff         <= i_in;
      d_ff         <= d_in;
      base_ff      <= base_in;
      sq_ff        <= sq_in;
      total_ff     <= total_in;
      raw_ff       <= raw_in;
      sum_ff       <= sum_in;
      seg_ff       <= seg_in;
      target_ff    <= target_in;
      prev_ff      <= prev_in;
      s_ff         <= s_in;
      lbase_ff     <= lbase_in;
      f_ff         <= f_in;
      err_ff       <= err_in;
      a_ff         <= a_in;
      out_idx_ff   <= out_idx_in;
      rsp_value_ff <= rsp_value_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_last_ff  <= rsp_last_in;
   end

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff != S_IDLE))
      else $error("result word strobed while sequencer idle");

   a_load_cap: assert property (@(posedge clock) disable iff (reset)
      load_idx_ff <= LOAD_W'(STORE_CAP))
      else $error("load index beyond store capacity");

   a_last_once: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |=> !rsp_valid_ff)
      else $error("result word after the last word of a run");

   a_left_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, left_ff} + CNT_W'(2) <= n_ff))
      else $error("left image beyond last segment");

endmodule

// ===== sv/polyline_arclength_resampler_unit.sv =====
// Top level of the equal arc-length polyline resampler.
// Usage:
//   Configuration: csr_valid/csr_ready with csr_index (0 inverse_mass, 1 step_time,
//   2 image_count, 3 dimension_count) and csr_wdata; always ready, write only while idle.
//   Input: a word is taken when start is high and busy is low. Words arrive in
//   row-major order (image by image); the word with req_last_element set starts a run.
//   Each load word takes two multiplies on the shared unit; the first word after any
//   register write adds a quotient divide unless inverse_mass is zero.
//   A run measures every segment (a square per coordinate plus a root), divides out
//   fractions, walks segments one per cycle and emits image_count*dimension_count
//   words, with at most one divide per image and a multiply per coordinate, then copies
//   the new coordinates back; all arithmetic runs on the one shared multiply/divide/root unit.
//   Results: rsp_valid strobes for one cycle per word with rsp_new_value,
//   rsp_error_flag and rsp_last_result; the receiver cannot stall.
//   Reset (synchronous) returns the gains to 1.0, counts to 8 and empties the load.
`timescale 1ns / 1ps
module polyline_arclength_resampler_unit import plar_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_pos_value,
   input  logic [31:0] req_grad_value,
   input  logic        req_last_element,
   output logic        rsp_valid,
   output logic [31:0] rsp_new_value,
   output logic        rsp_error_flag,
   output logic        rsp_last_result,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cfg_type     cfg_ff;
   logic        cfg_wr;
   alu_req_type alu_req;
   logic [63:0] alu_opa, alu_opb, alu_result;
   logic        alu_done;

   assign csr_ready = 1'b1;
   assign cfg_wr    = csr_valid && csr_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inv_mass    <= 32'h01000000;
         cfg_ff.step_time   <= 32'h01000000;
         cfg_ff.image_count <= CNT_W'(8);
         cfg_ff.dim_count   <= CNT_W'(8);
      end else if (cfg_wr) begin
         case (csr_index_type'(csr_index))
            REG_INV_MASS:    cfg_ff.inv_mass    <= csr_wdata;
            REG_STEP_TIME:   cfg_ff.step_time   <= csr_wdata;
            REG_IMAGE_COUNT: cfg_ff.image_count <= csr_wdata[CNT_W-1:0];
            REG_DIM_COUNT:   cfg_ff.dim_count   <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   plar_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .cfg_wr           (cfg_wr),
      .start            (start),
      .busy             (busy),
      .req_pos_value    (req_pos_value),
      .req_grad_value   (req_grad_value),
      .req_last_element (req_last_element),
      .rsp_valid        (rsp_valid),
      .rsp_new_value    (rsp_new_value),
      .rsp_error_flag   (rsp_error_flag),
      .rsp_last_result  (rsp_last_result),
      .alu_req          (alu_req),
      .alu_opa          (alu_opa),
      .alu_opb          (alu_opb),
      .alu_done         (alu_done),
      .alu_result       (alu_result)
   );

   plar_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .req    (alu_req),
      .opa    (alu_opa),
      .opb    (alu_opb),
      .done   (alu_done),
      .result (alu_result)
   );

endmodule

// ===== tb/tb_polyline_arclength_resampler_unit.sv =====
// Self-checking testbench for the equal arc-length polyline resampler.
`timescale 1ns / 1ps
module tb_polyline_arclength_resampler_unit import plar_pkg::*;;

   localparam int  ITEM_TARGET = 160;
   localparam int  SETTLE      = 400;
   localparam longint LIMIT    = 1500000;

   typedef struct {
      logic [31:0] value;
      logic        err;
      logic        last;
   } coord_word_type;

   logic        clock, reset, start, busy;
   logic [31:0] req_pos_value, req_grad_value;
   logic        req_last_element;
   logic        rsp_valid, rsp_error_flag, rsp_last_result;
   logic [31:0] rsp_new_value;
   logic        csr_valid, csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   polyline_arclength_resampler_unit DUT (.*);

   // predictor state
   logic [31:0] coord_mem [STORE_CAP];
   logic [63:0] written_mask;
   int          fill_index;
   logic [31:0] inv_mass_q24, step_q24;
   logic [3:0]  images_reg, dims_reg;

   coord_word_type expected_coords[$];
   int     fail_count, words_sent, words_checked, runs_done, idle_pct;
   longint cycle_count;

   // clock and timeout
   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic longint sx(logic [31:0] v);
      return longint'(signed'(v));
   endfunction

   function automatic logic [31:0] clip32(longint x);
      if (x > 64'sd2147483647) return 32'h7FFFFFFF;
      if (x < -64'sd2147483648) return 32'h80000000;
      return x[31:0];
   endfunction

   function automatic longint scale_q24(longint g, logic [31:0] k);
      longint p;
      p = g * longint'({32'b0, k});
      return (p + 64'sd8388608) >>> 24;
   endfunction

   function automatic longint unsigned root_floor(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'h1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      return r;
   endfunction

   // store one word; on the last mark resample and queue the new coordinates
   task automatic predict_resample(logic [31:0] pos, logic [31:0] grad, logic last);
      longint unsigned quo, total, acc, stp, prev, target, s, f, sq, q, ad;
      longint unsigned raw [MAX_IMAGES];
      logic [31:0] frac [MAX_IMAGES];
      logic [31:0] fresh [STORE_CAP];
      longint df, a, b, v;
      int n, m, left, k;
      bit err;
      coord_word_type w;
      if (inv_mass_q24 == 0) quo = 64'hFFFFFFFF;
      else begin
         quo = ({32'b0, step_q24} << 24) / inv_mass_q24;
         if (quo > 64'hFFFFFFFF) quo = 64'hFFFFFFFF;
      end
      if (fill_index < STORE_CAP) begin
         coord_mem[fill_index] = clip32(sx(pos) - scale_q24(sx(grad), inv_mass_q24)
                                        + scale_q24(sx(grad), quo[31:0]));
         written_mask[fill_index] = 1'b1;
         fill_index++;
      end
      if (!last) return;
      fill_index = 0;
      n = images_reg < 2 ? 2 : (images_reg > MAX_IMAGES ? MAX_IMAGES : images_reg);
      m = dims_reg < 1 ? 1 : (dims_reg > MAX_DIMS ? MAX_DIMS : dims_reg);
      // segment lengths in units of 2^-12
      total = 0;
      for (int i = 0; i + 1 < n; i++) begin
         sq = 0;
         for (int d = 0; d < m; d++) begin
            df = sx(coord_mem[(i + 1) * m + d]) - sx(coord_mem[i * m + d]);
            ad = df < 0 ? -df : df;
            q = (ad + 8) >> 4;
            sq += q * q;
         end
         raw[i] = root_floor(sq);
         total += raw[i];
      end
      // normalized fractions, last one closes the sum to one
      acc = 0;
      for (int i = 0; i + 1 < n; i++) begin
         if (total == 0) f = 0;
         else if (i + 2 == n) f = 64'h80000000 - acc;
         else f = (raw[i] << 31) / total;
         acc += f;
         frac[i] = f[31:0];
      end
      // walk to each target and interpolate
      stp = 64'h7FFFFFFF / (n - 1);
      left = 0; prev = 0; k = 0; err = 0;
      for (int j = 0; j < n; j++) begin
         target = j * stp;
         s = target > prev ? target - prev : 0;
         if (!err) begin
            while (s > frac[left]) begin
               if (left + 2 == n) begin
                  err = 1;
                  break;
               end
               prev += frac[left];
               s -= frac[left];
               left++;
            end
         end
         if (err) f = 64'h80000000;
         else if (frac[left] == 0) f = 0;
         else f = (s << 31) / frac[left];
         for (int d = 0; d < m; d++) begin
            a = sx(coord_mem[left * m + d]);
            b = sx(coord_mem[(left + 1) * m + d]);
            v = a + (((b - a) * longint'(f) + 64'sd1073741824) >>> 31);
            fresh[k] = clip32(v);
            w.value = fresh[k];
            w.err = err;
            w.last = (k == n * m - 1);
            expected_coords.push_back(w);
            k++;
         end
      end
      for (int i = 0; i < k; i++) begin
         coord_mem[i] = fresh[i];
         written_mask[i] = 1'b1;
      end
      runs_done++;
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         coord_word_type e;
         if (expected_coords.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("Unexpected word: value %h err %b last %b",
                        rsp_new_value, rsp_error_flag, rsp_last_result);
         end else begin
            e = expected_coords.pop_front();
            words_checked++;
            if (e.value !== rsp_new_value || e.err !== rsp_error_flag ||
                e.last !== rsp_last_result) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("Mismatch word %0d: exp %h/%b/%b got %h/%b/%b", words_checked,
                           e.value, e.err, e.last,
                           rsp_new_value, rsp_error_flag, rsp_last_result);
            end
         end
      end
   end

   // send one input word and wait for it to be taken
   task automatic send_word(logic [31:0] pos, logic [31:0] grad, logic last);
      @(negedge clock);
      if ($urandom_range(0, 99) < idle_pct) begin
         start = 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_pos_value = pos;
      req_grad_value = grad;
      req_last_element = last;
      start = 1;
      do @(posedge clock); while (busy);
      predict_resample(pos, grad, last);
      words_sent++;
   endtask

   // drain results and let the copy-back finish
   task automatic settle();
      @(negedge clock);
      start = 0;
      while (expected_coords.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] data);
      @(negedge clock);
      csr_valid = 1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_INV_MASS:    inv_mass_q24 = data;
         REG_STEP_TIME:   step_q24 = data;
         REG_IMAGE_COUNT: images_reg = data[3:0];
         REG_DIM_COUNT:   dims_reg = data[3:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic set_all(logic [31:0] im, logic [31:0] st, logic [31:0] n, logic [31:0] m);
      write_reg(REG_INV_MASS, im);
      write_reg(REG_STEP_TIME, st);
      write_reg(REG_IMAGE_COUNT, n);
      write_reg(REG_DIM_COUNT, m);
   endtask

   task automatic test_field_extremes();
      set_all(32'h01000000, 32'h01000000, 2, 1);
      send_word(32'h7FFFFFFF, 32'h80000000, 0);
      send_word(32'h80000000, 32'h7FFFFFFF, 1);
      settle();
      set_all(32'hFFFFFFFF, 32'hFFFFFFFF, 2, 1);
      send_word(32'h7FFFFFFF, 32'h7FFFFFFF, 0);
      send_word(32'h00000000, 32'hFFFFFFFF, 1);
      settle();
   endtask

   // identical images: zero total length, search runs off the end
   task automatic test_zero_total();
      set_all(32'h01000000, 32'h00800000, 2, 1);
      send_word(32'h00012345, 32'h00001000, 0);
      send_word(32'h00012345, 32'h00001000, 1);
      settle();
   endtask

   task automatic test_zero_segment();
      write_reg(REG_IMAGE_COUNT, 3);
      send_word(32'h00010000, 32'h0, 0);
      send_word(32'h00010000, 32'h0, 0);
      send_word(32'hFFFD0000, 32'h0, 1);
      settle();
   endtask

   task automatic test_zero_inverse_mass();
      set_all(32'h0, 32'h00000100, 2, 1);
      send_word(32'h00020000, 32'h00000003, 0);
      send_word(32'hFFFF8000, 32'hFFFFFFFD, 1);
      settle();
   endtask

   // counts below range clamp to two images of one coordinate
   task automatic test_count_clamp();
      set_all(32'h00C00000, 32'h02000000, 32'hFFFFFFF0, 32'hABCDEF00);
      send_word(32'h0000A000, 32'h00000200, 0);
      send_word(32'h00050000, 32'hFFFFF000, 1);
      settle();
   endtask

   // reload only the head of the store; the rest holds the last run's output
   task automatic test_partial_reload();
      write_reg(REG_IMAGE_COUNT, 3);
      send_word(32'h00040000, 32'h00000010, 0);
      send_word(32'h00001000, 32'h00000020, 0);
      send_word(32'hFFF00000, 32'h00000030, 1);
      settle();
      send_word(32'h00300000, 32'h00000040, 1);
      settle();
   endtask

   function automatic logic [31:0] pick_gain();
      case ($urandom_range(0, 5))
         0: return 32'h01000000;
         1: return 32'hFFFFFFFF;
         2: return 32'h0;
         3: return 32'h1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_count(int lo, int hi);
      if ($urandom_range(0, 99) < 20) return {$urandom} & 32'hFFFFFFF0 | $urandom_range(0, 15);
      return $urandom_range(lo, hi);
   endfunction

   task automatic test_random_loads();
      int n, m, need, len, style, phase;
      logic [31:0] img_pos [MAX_DIMS];
      logic [31:0] img_grad [MAX_DIMS];
      bit dup, covered;
      phase = 0;
      while (words_sent < ITEM_TARGET) begin
         case (phase % 4)
            0: idle_pct = 0;
            1: idle_pct = 65;
            2: idle_pct = 0;
            default: idle_pct = 9;
         endcase
         phase++;
         if ($urandom_range(0, 1) || phase == 1)
            set_all(pick_gain(), pick_gain(), pick_count(2, 4), pick_count(1, 3));
         if (phase == 6) set_all(32'h01000000, 32'h01000000, 8, 8);
         n = images_reg < 2 ? 2 : (images_reg > MAX_IMAGES ? MAX_IMAGES : images_reg);
         m = dims_reg < 1 ? 1 : (dims_reg > MAX_DIMS ? MAX_DIMS : dims_reg);
         need = n * m;
         len = need;
         covered = 1;
         for (int i = 0; i < need; i++) covered &= written_mask[i];
         if (covered && $urandom_range(0, 9) == 0) len = $urandom_range(1, need - 1);
         else if (need == STORE_CAP && $urandom_range(0, 2) == 0) len = need + $urandom_range(1, 3);
         style = $urandom_range(0, 9);
         for (int j = 0; j < len; j++) begin
            dup = (j >= m) && j < need &&
                  ((style == 0) || (style == 1 && $urandom_range(0, 2) == 0));
            if (!dup) begin
               if (style < 5) begin
                  img_pos[j % m] = $urandom;
                  img_grad[j % m] = $urandom;
               end else begin
                  img_pos[j % m] = 32'($signed($urandom_range(0, 2097152)) - 1048576);
                  img_grad[j % m] = 32'($signed($urandom_range(0, 8192)) - 4096);
               end
            end
            send_word(img_pos[j % m], img_grad[j % m], j == len - 1);
         end
         settle();
      end
   endtask

   initial begin
      reset = 1; start = 0; csr_valid = 0; csr_index = 0; csr_wdata = 0;
      req_pos_value = 0; req_grad_value = 0; req_last_element = 0;
      fail_count = 0; words_sent = 0; words_checked = 0; runs_done = 0;
      idle_pct = 0; cycle_count = 0;
      fill_index = 0; written_mask = '0;
      inv_mass_q24 = 32'h01000000; step_q24 = 32'h01000000;
      images_reg = 8; dims_reg = 8;
      foreach (coord_mem[i]) coord_mem[i] = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      test_field_extremes();
      test_zero_total();
      test_zero_segment();
      test_zero_inverse_mass();
      test_count_clamp();
      test_partial_reload();
      test_random_loads();
      settle();
      if (expected_coords.size() != 0) fail_count++;

      $display("Sent %0d load words over %0d resample runs, checked %0d output words,",
               words_sent, runs_done, words_checked);
      $display("covering gain extremes, count clamping, partial and overflowing loads.");
      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/plar_pkg.sv
sv/plar_alu.sv
sv/plar_ctrl.sv
sv/polyline_arclength_resampler_unit.sv
tb/tb_polyline_arclength_resampler_unit.sv
